/* rtl/core/afrd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afrd_pkg: shared types and constants for the audio frame ring
// Command codes, controller/datapath handshake structs, sample scaling.
// ----------------------------------------------------------------------------
package afrd_pkg;

	localparam int unsigned AFRD_RING_FRAMES = 4096;
	localparam int unsigned AFRD_MAX_BURST   = 64;

	localparam int unsigned AFRD_SAMPLE_IN_W  = 18;
	localparam int unsigned AFRD_SAMPLE_OUT_W = 16;
	localparam int unsigned AFRD_MAXF_W       = 7;
	localparam int unsigned AFRD_DROP_W       = 32;
	localparam int unsigned AFRD_S_TDATA_W    = 48;
	localparam int unsigned AFRD_M_TDATA_W    = 64;
	localparam int unsigned AFRD_CMD_W        = 2;

	localparam logic [AFRD_CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [AFRD_CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [AFRD_CMD_W-1:0] CMD_CLEAR = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic do_write;
		logic do_clear;
		logic start_read;
		logic fetch;
		logic load_frame;
		logic load_empty;
	} afrd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic burst_zero;
		logic last_pending;
		logic out_free;
	} afrd_stat_t;

	// Clamp Q2.15 to +/-1.0, scale by 32767/32768, truncate toward zero.
	function automatic logic [AFRD_SAMPLE_OUT_W-1:0] afrd_scale(
		input logic signed [AFRD_SAMPLE_IN_W-1:0] x);
		logic signed [AFRD_SAMPLE_IN_W-1:0] c;
		logic signed [32:0] p;
		logic signed [32:0] adj;
		if (x > 18'sd32768) begin
			c = 18'sd32768;
		end else if (x < -18'sd32768) begin
			c = -18'sd32768;
		end else begin
			c = x;
		end
		p = 33'(c) * 33'sd32767;
		// bias negatives so the shift rounds toward zero
		adj = (p < 0) ? (p + 33'sd32767) : p;
		return adj[30:15];
	endfunction

endpackage
`default_nettype wire

/* rtl/core/audio_frame_ring_drop_oldest.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_frame_ring_drop_oldest: stereo frame FIFO with drop-oldest overflow
// Scales Q2.15 frames to signed 16 bits, stores them in a ring and returns
// them in read bursts; a full ring discards its oldest frame.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tuser: cmd; tdata: left, right, max_frames
// m_axis    out  tvalid/tready          tdata: left, right, dropped; tlast; tuser
// cfg       in   cfg_we                 cfg_wdata: tap_enable
//
// Sequence: a write, clear or ignored transaction is done in the idle state,
// so writes stream at one frame per clock while no read burst runs. A read
// burst is accepted, then each frame takes a registered read of the ring
// memory and a load of the output register. An empty read answers once.
// Reset clears pointers, fill count, drop counter and tap_enable at once;
// the ring memory itself is not cleared, so there is no startup pass.
// Stalls: the output register holds a result until taken; writes keep
// flowing while a burst's last result waits; a burst pauses until the slot frees.
// ----------------------------------------------------------------------------
module audio_frame_ring_drop_oldest
	import afrd_pkg::*;
#(
	parameter int unsigned RING_FRAMES = AFRD_RING_FRAMES,
	parameter int unsigned MAX_BURST   = AFRD_MAX_BURST
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// tap_enable register write
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_wdata,
	// input stream
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	// [17:0] left_sample, [35:18] right_sample, [42:36] max_frames, rest zero
	input  wire logic [AFRD_S_TDATA_W-1:0] s_axis_tdata,
	// [1:0] cmd
	input  wire logic [AFRD_CMD_W-1:0]     s_axis_tuser,
	// result stream
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// [15:0] left_out, [31:16] right_out, [63:32] dropped_frames
	output logic [AFRD_M_TDATA_W-1:0]      m_axis_tdata,
	output logic                           m_axis_tlast,
	// [0] none_available
	output logic                           m_axis_tuser
);

	afrd_cmd_t  cmd;
	afrd_stat_t stat;

	logic signed [AFRD_SAMPLE_IN_W-1:0]  left_sample;
	logic signed [AFRD_SAMPLE_IN_W-1:0]  right_sample;
	logic        [AFRD_MAXF_W-1:0]       max_frames;
	logic signed [AFRD_SAMPLE_OUT_W-1:0] left_out;
	logic signed [AFRD_SAMPLE_OUT_W-1:0] right_out;
	logic        [AFRD_DROP_W-1:0]       dropped_frames;

	// unpack the input transaction
	assign left_sample  = s_axis_tdata[17:0];
	assign right_sample = s_axis_tdata[35:18];
	assign max_frames   = s_axis_tdata[42:36];

	afrd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.kind    (s_axis_tuser),
		.s_ready (s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	afrd_datapath #(
		.RING_FRAMES (RING_FRAMES),
		.MAX_BURST   (MAX_BURST)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.max_frames     (max_frames),
		.cmd            (cmd),
		.stat           (stat),
		.m_tready       (m_axis_tready),
		.m_valid        (m_axis_tvalid),
		.left_out       (left_out),
		.right_out      (right_out),
		.last           (m_axis_tlast),
		.none_available (m_axis_tuser),
		.dropped_frames (dropped_frames)
	);

	// pack the result transaction
	assign m_axis_tdata = {dropped_frames, right_out, left_out};

endmodule
`default_nettype wire

/* rtl/core/afrd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afrd_datapath: ring memory, pointers, drop counter and output register
// Executes the commands of the controller and reports burst status.
// ----------------------------------------------------------------------------
module afrd_datapath
	import afrd_pkg::*;
#(
	parameter int unsigned RING_FRAMES = AFRD_RING_FRAMES,
	parameter int unsigned MAX_BURST   = AFRD_MAX_BURST
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_wdata,
	input  wire logic signed [AFRD_SAMPLE_IN_W-1:0]  left_sample,
	input  wire logic signed [AFRD_SAMPLE_IN_W-1:0]  right_sample,
	input  wire logic        [AFRD_MAXF_W-1:0]       max_frames,
	input  wire afrd_cmd_t                           cmd,
	output afrd_stat_t                               stat,
	input  wire logic                                m_tready,
	output logic                                     m_valid,
	output logic signed [AFRD_SAMPLE_OUT_W-1:0]      left_out,
	output logic signed [AFRD_SAMPLE_OUT_W-1:0]      right_out,
	output logic                                     last,
	output logic                                     none_available,
	output logic        [AFRD_DROP_W-1:0]            dropped_frames
);

	localparam int unsigned IDX_W   = $clog2(RING_FRAMES);
	localparam int unsigned FILL_W  = $clog2(RING_FRAMES + 1);
	localparam int unsigned SUM_W   = FILL_W + 1;
	localparam int unsigned BURST_W = $clog2(MAX_BURST + 1);
	localparam int unsigned CMP_W   = (FILL_W > AFRD_MAXF_W) ? FILL_W : AFRD_MAXF_W;
	localparam int unsigned WORD_W  = 2 * AFRD_SAMPLE_OUT_W;

	localparam logic [FILL_W-1:0]      FILL_FULL = FILL_W'(RING_FRAMES);
	localparam logic [SUM_W-1:0]       RING_S    = SUM_W'(RING_FRAMES);
	localparam logic [IDX_W-1:0]       HEAD_LAST = IDX_W'(RING_FRAMES - 1);
	localparam logic [AFRD_MAXF_W-1:0] BURST_CAP = AFRD_MAXF_W'(MAX_BURST);

	logic [WORD_W-1:0] mem [RING_FRAMES];
	logic [WORD_W-1:0] rdata_s1;
	logic              last_s1;

	logic                   tap_enable_q;
	logic [IDX_W-1:0]       head_q;
	logic [FILL_W-1:0]      fill_q;
	logic [AFRD_DROP_W-1:0] drop_q;
	logic [BURST_W-1:0]     rem_q;

	logic                   out_valid_q;
	logic [WORD_W-1:0]      out_word_q;
	logic                   out_last_q;
	logic                   out_none_q;
	logic [AFRD_DROP_W-1:0] out_drop_q;

	logic                   full;
	logic                   wr_en;
	logic [IDX_W-1:0]       head_inc;
	logic [SUM_W-1:0]       sum;
	logic [SUM_W-1:0]       sum_wrap;
	logic [IDX_W-1:0]       wr_idx;
	logic [WORD_W-1:0]      wr_word;
	logic [AFRD_MAXF_W-1:0] lim;
	logic [CMP_W-1:0]       lim_x;
	logic [CMP_W-1:0]       fill_x;
	logic [CMP_W-1:0]       burst_n;

	always_comb begin
		full     = (fill_q == FILL_FULL);
		wr_en    = cmd.do_write && tap_enable_q;
		head_inc = (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
		sum      = SUM_W'(head_q) + SUM_W'(fill_q);
		sum_wrap = (sum >= RING_S) ? (sum - RING_S) : sum;
		// full ring: the new frame takes the slot of the dropped oldest one
		wr_idx   = full ? head_q : sum_wrap[IDX_W-1:0];
		wr_word  = {afrd_scale(right_sample), afrd_scale(left_sample)};
		lim      = (max_frames > BURST_CAP) ? BURST_CAP : max_frames;
		lim_x    = CMP_W'(lim);
		fill_x   = CMP_W'(fill_q);
		burst_n  = (lim_x > fill_x) ? fill_x : lim_x;
	end

	assign stat.burst_zero   = (burst_n == '0);
	assign stat.last_pending = last_s1;
	assign stat.out_free     = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_word;
		end
		if (cmd.fetch) begin
			rdata_s1 <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_enable_q <= 1'b0;
			head_q       <= '0;
			fill_q       <= '0;
			drop_q       <= '0;
			rem_q        <= '0;
			last_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				tap_enable_q <= cfg_wdata;
			end
			if (cmd.do_clear) begin
				head_q <= '0;
				fill_q <= '0;
				drop_q <= '0;
			end else if (wr_en) begin
				if (full) begin
					head_q <= head_inc;
					if (drop_q != '1) begin
						drop_q <= drop_q + 1'b1;
					end
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (cmd.fetch) begin
				head_q <= head_inc;
				fill_q <= fill_q - 1'b1;
			end
			if (cmd.start_read) begin
				rem_q <= burst_n[BURST_W-1:0];
			end else if (cmd.fetch) begin
				rem_q   <= rem_q - 1'b1;
				last_s1 <= (rem_q == BURST_W'(1));
			end
			if (cmd.load_frame || cmd.load_empty) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_frame) begin
			out_word_q <= rdata_s1;
			out_last_q <= last_s1;
			out_none_q <= 1'b0;
			out_drop_q <= drop_q;
		end else if (cmd.load_empty) begin
			out_word_q <= '0;
			out_last_q <= 1'b1;
			out_none_q <= 1'b1;
			out_drop_q <= drop_q;
		end
	end

	assign m_valid        = out_valid_q;
	assign left_out       = out_word_q[AFRD_SAMPLE_OUT_W-1:0];
	assign right_out      = out_word_q[WORD_W-1:AFRD_SAMPLE_OUT_W];
	assign last           = out_last_q;
	assign none_available = out_none_q;
	assign dropped_frames = out_drop_q;

endmodule
`default_nettype wire

/* rtl/core/afrd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afrd_ctrl: command sequencer of the audio frame ring
// Decodes input transactions and steps read bursts frame by frame.
// ----------------------------------------------------------------------------
module afrd_ctrl
	import afrd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_valid,
	input  wire logic [AFRD_CMD_W-1:0] kind,
	output logic                       s_ready,
	input  wire afrd_stat_t            stat,
	output afrd_cmd_t                  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_EMPTY
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   take;

	assign s_ready = (state_q == ST_IDLE);
	assign take    = s_valid && s_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (kind)
						CMD_WRITE: cmd.do_write = 1'b1;
						CMD_CLEAR: cmd.do_clear = 1'b1;
						CMD_READ: begin
							cmd.start_read = 1'b1;
							state_d = stat.burst_zero ? ST_EMPTY : ST_FETCH;
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				// issue the read only when the output slot is free next cycle
				if (stat.out_free) begin
					cmd.fetch = 1'b1;
					state_d   = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load_frame = 1'b1;
				state_d = stat.last_pending ? ST_IDLE : ST_FETCH;
			end
			ST_EMPTY: begin
				if (stat.out_free) begin
					cmd.load_empty = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/afrd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afrd_checker: port-level checks for the audio frame ring
// Watches the result stream and flags protocol or content slips.
// ----------------------------------------------------------------------------
module afrd_checker
	import afrd_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      m_axis_tvalid,
	input wire logic                      m_axis_tready,
	input wire logic [AFRD_M_TDATA_W-1:0] m_axis_tdata,
	input wire logic                      m_axis_tlast,
	input wire logic                      m_axis_tuser
);

	// hold a stalled result
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result payload changed while stalled");

	// an empty answer closes its burst and carries zero samples
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[31:0] == 32'd0))
		else $error("empty answer malformed");

	// scaling never yields the most negative code
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:0] != 16'h8000) && (m_axis_tdata[31:16] != 16'h8000))
		else $error("sample out of range");

	// the drop count stays the same inside one burst
	a_drop_mono: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
		|-> m_axis_tdata[63:32] == $past(m_axis_tdata[63:32]))
		else $error("drop count changed within a burst");

endmodule

bind audio_frame_ring_drop_oldest afrd_checker u_afrd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
